>>> rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants for the button debounce / long press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

   localparam int BUTTONS     = 4;
   localparam int SAMPLE_BITS = 4;
   localparam int CNT_W       = 10;

   localparam logic [CNT_W-1:0] HOLD_RESET = 10'd100;

   localparam logic [1:0] KIND_TICK       = 2'd0;
   localparam logic [1:0] KIND_READ_SHORT = 2'd1;
   localparam logic [1:0] KIND_READ_LONG  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] samples;
      logic [2:0] index;
   } req_item_type;

   typedef struct packed {
      logic answer;
      logic index_error;
   } rsp_item_type;

   // per-button control from the item decode
   typedef struct packed {
      logic tick;
      logic clr_press;
      logic clr_long;
   } btn_ctrl_type;

   // per-button flags seen by the query path
   typedef struct packed {
      logic press;
      logic long_hold;
   } btn_flags_type;

endpackage

>>> rtl/bdlp_button.sv
// ----------------------------------------------------------------------------
// bdlp_button
// debounce history, stable level, hold counter and flags of one button
// ----------------------------------------------------------------------------
module bdlp_button (
   input  logic                        clock,
   input  logic                        reset,
   input  bdlp_pkg::btn_ctrl_type      ctrl,
   input  logic                        raw,
   input  logic [bdlp_pkg::CNT_W-1:0]  hold_ticks,
   output bdlp_pkg::btn_flags_type     flags
);

   // the older sample of the history is the current newest_ff at each tick,
   // so only the newest one needs a register
   logic                       newest_ff, newest_in;
   logic                       stable_ff, stable_in;
   logic                       press_ff, press_in;
   logic                       long_ff, long_in;
   logic [bdlp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [bdlp_pkg::CNT_W-1:0] cnt_dec;

   assign cnt_dec = cnt_ff - 1'b1;

   always_comb begin
      newest_in = newest_ff;
      stable_in = stable_ff;
      press_in  = press_ff;
      long_in   = long_ff;
      cnt_in    = cnt_ff;
      if (ctrl.tick) begin
         newest_in = raw;
         // two agreeing samples
         if (raw == newest_ff) begin
            if (newest_ff != stable_ff) begin
               stable_in = newest_ff;
               if (!newest_ff) begin
                  press_in = 1'b1;
                  cnt_in   = hold_ticks;
               end
            end else if (cnt_dec == '0) begin
               cnt_in = hold_ticks;
               if (!stable_ff) begin
                  press_in = 1'b0;
                  long_in  = 1'b1;
               end else begin
                  long_in = 1'b0;
               end
            end else begin
               cnt_in = cnt_dec;
            end
         end
      end
      if (ctrl.clr_press) press_in = 1'b0;
      if (ctrl.clr_long)  long_in  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= 1'b1;
         stable_ff <= 1'b1;
         press_ff  <= 1'b0;
         long_ff   <= 1'b0;
         cnt_ff    <= bdlp_pkg::HOLD_RESET;
      end else begin
         newest_ff <= newest_in;
         stable_ff <= stable_in;
         press_ff  <= press_in;
         long_ff   <= long_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign flags.press     = press_ff;
   assign flags.long_hold = long_ff;

endmodule

>>> rtl/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// four-button debouncer with short press latch and long press flag
// ----------------------------------------------------------------------------
//
//  port group  dir  handshake           payload
//  req_        in   req_valid/ready     req_payload (kind, samples, index)
//  rsp_        out  rsp_valid/ready     rsp_payload (answer, index_error)
//  csr_        in   csr_wr_en           csr_wr_data (hold_ticks)
//
// an item is captured into an input register, then in one pass updates the
// per-button state and lands in the result register: one item per cycle
// sustained while rsp_ready allows. the result register is the only place that
// holds a finished item; a stalled rsp_ready holds it and, once the input
// register is also full, drops req_ready. synchronous reset brings all buttons
// to released with hold counters at 100 and hold_ticks at 100.
//
module button_debounce_long_press_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bdlp_pkg::req_item_type         req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bdlp_pkg::rsp_item_type         rsp_payload,
   input  logic                           csr_wr_en,
   input  logic [bdlp_pkg::CNT_W-1:0]     csr_wr_data
);

   // configuration
   logic [bdlp_pkg::CNT_W-1:0] hold_ff;

   // input register
   logic                   s1_valid_ff;
   bdlp_pkg::req_item_type s1_item_ff;

   // result register
   logic                   rsp_valid_ff;
   bdlp_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic advance;
   logic is_tick, is_short, is_long;

   logic [bdlp_pkg::BUTTONS-1:0] hit;
   logic [bdlp_pkg::BUTTONS-1:0] press_vec;
   logic [bdlp_pkg::BUTTONS-1:0] long_vec;
   logic [bdlp_pkg::BUTTONS-1:0] raw_vec;

   bdlp_pkg::btn_ctrl_type  ctrl [bdlp_pkg::BUTTONS];
   bdlp_pkg::btn_flags_type flags [bdlp_pkg::BUTTONS];

   // input item moves into the result register when that one is free
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign is_tick  = advance && (s1_item_ff.kind == bdlp_pkg::KIND_TICK);
   assign is_short = advance && (s1_item_ff.kind == bdlp_pkg::KIND_READ_SHORT);
   assign is_long  = advance && (s1_item_ff.kind == bdlp_pkg::KIND_READ_LONG);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= bdlp_pkg::HOLD_RESET;
      end else if (csr_wr_en) begin
         hold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_payload;
      end
   end

   // button lanes: decode of the query index and of the sample bits
   for (genvar i = 0; i < bdlp_pkg::BUTTONS; i++) begin : g_btn
      assign hit[i] = ({29'd0, s1_item_ff.index} == 32'(i));
      if (i < bdlp_pkg::SAMPLE_BITS) begin : g_pin
         assign raw_vec[i] = s1_item_ff.samples[i];
      end else begin : g_nopin
         // no pin for this button: reads as released
         assign raw_vec[i] = 1'b1;
      end
      assign ctrl[i].tick      = is_tick;
      assign ctrl[i].clr_press = is_short && hit[i];
      assign ctrl[i].clr_long  = is_long && hit[i];

      bdlp_button u_button (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[i]),
         .raw        (raw_vec[i]),
         .hold_ticks (hold_ff),
         .flags      (flags[i])
      );

      assign press_vec[i] = flags[i].press;
      assign long_vec[i]  = flags[i].long_hold;
   end

   // query answer from the flags before this item clears them
   always_comb begin
      rsp_item_in.answer      = 1'b0;
      rsp_item_in.index_error = 1'b0;
      case (s1_item_ff.kind)
         bdlp_pkg::KIND_READ_SHORT: begin
            rsp_item_in.answer      = |(press_vec & hit);
            rsp_item_in.index_error = ~|hit;
         end
         bdlp_pkg::KIND_READ_LONG: begin
            rsp_item_in.answer      = |(long_vec & hit);
            rsp_item_in.index_error = ~|hit;
         end
         default: begin
            // ticks and unused kind: answer 0, no error
            rsp_item_in.answer      = 1'b0;
            rsp_item_in.index_error = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule
